FILE: hdl/sabc_pkg.sv
package sabc_pkg;

    localparam int NF_W = 10;
    localparam int VT_W = 13;
    localparam int PT_W = 10;

    localparam logic [NF_W-1:0] NOISE_FLOOR_RST = NF_W'(10);
    localparam logic [VT_W-1:0] VISIBLE_THR_RST = VT_W'(10);
    localparam logic [PT_W-1:0] POSSESS_THR_RST = PT_W'(100);

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_NOISE_FLOOR = 2'd0;
    localparam logic [1:0] REG_VISIBLE_THR = 2'd1;
    localparam logic [1:0] REG_POSSESS_THR = 2'd2;

    // sensor angles, Q2.13 radians; left side is the negative of these
    localparam logic signed [15:0] ANGLE_REAR = 16'sd19302;
    localparam logic signed [15:0] ANGLE_SIDE = 16'sd6434;
    localparam logic signed [15:0] ANGLE_NEAR = 16'sd1638;

    // |bearing| <= 19302 < 2**15
    localparam int QUOT_BITS = 15;
    localparam int Q_DEPTH   = 4;

    typedef enum logic [1:0] {
        STATUS_NOT_SEEN  = 2'd0,
        STATUS_VISIBLE   = 2'd1,
        STATUS_POSSESSED = 2'd2
    } t_status;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

FILE: hdl/sabc_front.sv
module sabc_front import sabc_pkg::*; #(
    parameter int SB = 10,
    parameter int EW = 2 * SB + 22
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [NF_W-1:0]   i_noise_floor,
    input  logic [VT_W-1:0]   i_visible_thr,
    input  logic [PT_W-1:0]   i_possess_thr,
    input  logic              s_tvalid,
    output logic              s_tready,
    // fields from bit 0: rear_left, left, near_left, center, near_right, right,
    // rear_right, possession
    input  logic [8*SB-1:0]   s_tdata,
    input  t_q_flags          i_q_flags,
    output logic              o_push,
    // fields from bit 0: mag, total, neg, nonzero, status
    output logic [EW-1:0]     o_entry
);

    localparam int TW  = SB + 3;
    localparam int MW  = SB + 15;
    localparam int MSW = SB + 16;
    localparam int CW  = (SB > NF_W) ? SB : NF_W;
    localparam int VW  = (TW > VT_W) ? TW : VT_W;

    logic [SB-1:0] r_g [7];
    logic [SB-1:0] n_g [7];
    logic          r_poss;
    logic          n_poss;
    logic          r_vld;
    logic          w_accept;

    logic [TW-1:0]         w_total;
    logic signed [SB:0]    w_d_rear, w_d_side, w_d_near;
    logic signed [MSW-1:0] w_moment;
    logic [MSW-1:0]        w_mag_full;
    logic                  w_neg;
    t_status               w_status;

    assign s_tready = !r_vld || !i_q_flags.full;
    assign w_accept = s_tvalid && s_tready;
    assign o_push   = r_vld && !i_q_flags.full;

    always_comb begin
        for (int k = 0; k < 7; k++) begin
            n_g[k] = s_tdata[k*SB +: SB];
            if (CW'(n_g[k]) < CW'(i_noise_floor)) begin
                n_g[k] = '0;
            end
        end
        n_poss = CW'(s_tdata[7*SB +: SB]) > CW'(i_possess_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
        if (w_accept) begin
            r_g    <= n_g;
            r_poss <= n_poss;
        end
    end

    always_comb begin
        w_total = '0;
        for (int k = 0; k < 7; k++) begin
            w_total = w_total + TW'(r_g[k]);
        end
        w_d_rear = $signed({1'b0, r_g[6]}) - $signed({1'b0, r_g[0]});
        w_d_side = $signed({1'b0, r_g[5]}) - $signed({1'b0, r_g[1]});
        w_d_near = $signed({1'b0, r_g[4]}) - $signed({1'b0, r_g[2]});
        w_moment = MSW'(w_d_rear) * MSW'(ANGLE_REAR)
                 + MSW'(w_d_side) * MSW'(ANGLE_SIDE)
                 + MSW'(w_d_near) * MSW'(ANGLE_NEAR);
        w_neg      = w_moment[MSW-1];
        w_mag_full = w_neg ? MSW'(-w_moment) : MSW'(w_moment);
        if (r_poss) begin
            w_status = STATUS_POSSESSED;
        end else if (VW'(w_total) > VW'(i_visible_thr)) begin
            w_status = STATUS_VISIBLE;
        end else begin
            w_status = STATUS_NOT_SEEN;
        end
    end

    assign o_entry = {w_status, (w_total != '0), w_neg, w_total, w_mag_full[MW-1:0]};

endmodule

FILE: hdl/sabc_queue.sv
module sabc_queue import sabc_pkg::*; #(
    parameter int EW = 42
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [EW-1:0] i_data,
    input  logic          i_pop,
    output logic [EW-1:0] o_data,
    output t_q_flags      o_flags
);

    localparam int PW = $clog2(Q_DEPTH);

    logic [EW-1:0] r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    assign o_data        = r_mem[r_rd_ptr];
    assign o_flags.full  = (r_count == (PW+1)'(Q_DEPTH));
    assign o_flags.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_flags.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_flags.empty)
        else $error("queue pop while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + (PW+1)'(1)))
        else $error("queue count lost a push");

endmodule

FILE: hdl/sabc_back.sv
module sabc_back import sabc_pkg::*; #(
    parameter int SB = 10,
    parameter int EW = 2 * SB + 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [EW-1:0] i_entry,
    input  t_q_flags      i_q_flags,
    output logic          o_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    // fields from bit 0: bearing
    output logic [15:0]   m_tdata,
    // fields from bit 0: bearing_valid, target_status[1:0]
    output logic [2:0]    m_tuser
);

    localparam int TW = SB + 3;
    localparam int MW = SB + 15;
    localparam int DW = TW + QUOT_BITS;
    localparam int NS = QUOT_BITS + 1;

    logic                 r_vld   [NS];
    logic [MW-1:0]        r_rem   [NS];
    logic [TW-1:0]        r_tot   [NS];
    logic [QUOT_BITS-1:0] r_quo   [NS];
    logic                 r_neg   [NS];
    logic                 r_nz    [NS];
    t_status              r_stat  [NS];
    logic [MW-1:0]        n_rem   [NS];
    logic [QUOT_BITS-1:0] n_quo   [NS];

    logic        r_out_vld;
    logic [15:0] r_bearing;
    logic        r_out_nz;
    t_status     r_out_stat;
    logic        w_en;
    logic [15:0] w_bearing;
    logic [DW-1:0] w_shift [NS];

    assign w_en  = !r_out_vld || m_tready;
    assign o_pop = w_en && !i_q_flags.empty;

    // one quotient bit per stage, most significant first
    always_comb begin
        n_rem[0]   = i_entry[MW-1:0];
        n_quo[0]   = '0;
        w_shift[0] = '0;
        for (int j = 1; j < NS; j++) begin
            w_shift[j] = DW'(r_tot[j-1]) << (QUOT_BITS - j);
            n_rem[j]   = r_rem[j-1];
            n_quo[j]   = r_quo[j-1];
            if (DW'(r_rem[j-1]) >= w_shift[j]) begin
                n_rem[j] = MW'(DW'(r_rem[j-1]) - w_shift[j]);
                n_quo[j][QUOT_BITS - j] = 1'b1;
            end
        end
    end

    always_comb begin
        w_bearing = 16'(r_quo[NS-1]);
        if (!r_nz[NS-1]) begin
            w_bearing = '0;
        end else if (r_neg[NS-1]) begin
            w_bearing = -w_bearing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NS; j++) begin
                r_vld[j] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= o_pop;
            for (int j = 1; j < NS; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
            r_out_vld <= r_vld[NS-1];
        end
        if (w_en) begin
            r_rem[0]  <= n_rem[0];
            r_quo[0]  <= n_quo[0];
            r_tot[0]  <= i_entry[MW +: TW];
            r_neg[0]  <= i_entry[MW+TW];
            r_nz[0]   <= i_entry[MW+TW+1];
            r_stat[0] <= t_status'(i_entry[MW+TW+2 +: 2]);
            for (int j = 1; j < NS; j++) begin
                r_rem[j]  <= n_rem[j];
                r_quo[j]  <= n_quo[j];
                r_tot[j]  <= r_tot[j-1];
                r_neg[j]  <= r_neg[j-1];
                r_nz[j]   <= r_nz[j-1];
                r_stat[j] <= r_stat[j-1];
            end
            r_bearing  <= w_bearing;
            r_out_nz   <= r_nz[NS-1];
            r_out_stat <= r_stat[NS-1];
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_bearing;
    assign m_tuser  = {r_out_stat, r_out_nz};

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 16'd0))
        else $error("bearing not zero on invalid word");

endmodule

FILE: hdl/sensor_array_bearing_centroid.sv
// Weighted-centroid bearing for an eight-sensor ring: each input word is one sweep of
// eight samples, each output word is the noise-gated weighted mean angle (signed Q2.13
// radians, truncated toward zero), a valid flag and a not seen / visible / possessed
// status. One sweep is taken per clock while the queue is not full; each accepted sweep passes
// through the gate/multiply-accumulate stage, a 4-word queue and the 15-stage restoring
// divider (one quotient bit per stage), in that order. Registers: noise_floor at 0x0,
// visible_threshold at 0x4, possession_threshold at 0x8; write them only while idle.
module sensor_array_bearing_centroid import sabc_pkg::*; #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // fields from bit 0: rear_left, left, near_left, center, near_right, right,
    // rear_right, possession
    input  logic [8*SAMPLE_BITS-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // fields from bit 0: bearing
    output logic [15:0]              m_tdata,
    // fields from bit 0: bearing_valid, target_status[1:0]
    output logic [2:0]               m_tuser
);

    localparam int EW = 2 * SAMPLE_BITS + 22;

    logic [NF_W-1:0] r_noise_floor;
    logic [VT_W-1:0] r_visible_thr;
    logic [PT_W-1:0] r_possess_thr;
    logic            w_wr;

    t_q_flags        w_q_flags;
    logic            w_push;
    logic            w_pop;
    logic [EW-1:0]   w_push_data;
    logic [EW-1:0]   w_pop_data;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_floor <= NOISE_FLOOR_RST;
            r_visible_thr <= VISIBLE_THR_RST;
            r_possess_thr <= POSSESS_THR_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_NOISE_FLOOR: r_noise_floor <= pwdata[NF_W-1:0];
                REG_VISIBLE_THR: r_visible_thr <= pwdata[VT_W-1:0];
                REG_POSSESS_THR: r_possess_thr <= pwdata[PT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_NOISE_FLOOR: prdata = 32'(r_noise_floor);
            REG_VISIBLE_THR: prdata = 32'(r_visible_thr);
            REG_POSSESS_THR: prdata = 32'(r_possess_thr);
            default:         prdata = '0;
        endcase
    end

    sabc_front #(.SB(SAMPLE_BITS), .EW(EW)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_noise_floor (r_noise_floor),
        .i_visible_thr (r_visible_thr),
        .i_possess_thr (r_possess_thr),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .i_q_flags     (w_q_flags),
        .o_push        (w_push),
        .o_entry       (w_push_data)
    );

    sabc_queue #(.EW(EW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_flags (w_q_flags)
    );

    sabc_back #(.SB(SAMPLE_BITS), .EW(EW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_entry   (w_pop_data),
        .i_q_flags (w_q_flags),
        .o_pop     (w_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: tb/sensor_array_bearing_centroid_tb.sv
module sensor_array_bearing_centroid_tb;
    import sabc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = 10;
    localparam int NUM_SENSORS = 8;
    localparam int SMP_MAX = (1 << SAMPLE_W) - 1;
    localparam int VIS_MAX = 7 * SMP_MAX;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic signed [15:0] bearing;
        logic               valid;
        t_status            status;
    } t_sweep_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [ADDR_W-1:0]              paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [NUM_SENSORS*SAMPLE_W-1:0] s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [15:0]                    m_tdata;
    logic [2:0]                     m_tuser;

    logic [NF_W-1:0] floor_cfg = NOISE_FLOOR_RST;
    logic [VT_W-1:0] visible_cfg = VISIBLE_THR_RST;
    logic [PT_W-1:0] possess_cfg = POSSESS_THR_RST;

    t_sweep_result pending_bearings[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    sensor_array_bearing_centroid #(
        .SAMPLE_BITS(SAMPLE_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_sweep_result centroid_of(input logic [NUM_SENSORS*SAMPLE_W-1:0] word);
        longint angle[7];
        longint total;
        longint moment;
        longint mag;
        longint quot;
        longint s;
        t_sweep_result r;
        angle = '{-longint'(ANGLE_REAR), -longint'(ANGLE_SIDE), -longint'(ANGLE_NEAR), 0,
                  longint'(ANGLE_NEAR), longint'(ANGLE_SIDE), longint'(ANGLE_REAR)};
        total = 0;
        moment = 0;
        for (int k = 0; k < 7; k++) begin
            s = longint'(word[k*SAMPLE_W +: SAMPLE_W]);
            if (s < longint'(floor_cfg)) s = 0;
            total += s;
            moment += s * angle[k];
        end
        r.bearing = '0;
        r.valid = 1'b0;
        if (total != 0) begin
            mag = (moment < 0) ? -moment : moment;
            quot = mag / total;
            r.bearing = 16'((moment < 0) ? -quot : quot);
            r.valid = 1'b1;
        end
        if (longint'(word[7*SAMPLE_W +: SAMPLE_W]) > longint'(possess_cfg))
            r.status = STATUS_POSSESSED;
        else if (total > longint'(visible_cfg))
            r.status = STATUS_VISIBLE;
        else
            r.status = STATUS_NOT_SEEN;
        return r;
    endfunction

    function automatic logic [NUM_SENSORS*SAMPLE_W-1:0] make_sweep(
        input int rear_l, input int left, input int near_l, input int center,
        input int near_r, input int right, input int rear_r, input int possession);
        return {SAMPLE_W'(possession), SAMPLE_W'(rear_r), SAMPLE_W'(right), SAMPLE_W'(near_r),
                SAMPLE_W'(center), SAMPLE_W'(near_l), SAMPLE_W'(left), SAMPLE_W'(rear_l)};
    endfunction

    // weighted toward zero, full scale and the region around the thresholds
    function automatic int pick_sample(input int pivot);
        int v;
        case ($urandom_range(9))
            0: v = 0;
            1: v = SMP_MAX;
            2, 3: v = pivot + int'($urandom_range(4)) - 2;
            default: v = $urandom_range(SMP_MAX);
        endcase
        if (v < 0) v = 0;
        if (v > SMP_MAX) v = SMP_MAX;
        return v;
    endfunction

    task automatic send_sweep(input logic [NUM_SENSORS*SAMPLE_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pending_bearings.push_back(centroid_of(word));
        @(negedge i_clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_bearings.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // upper bits carry junk to exercise masking; readback checks the stored value
    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        int width;
        logic [31:0] raw;
        logic [31:0] stored;
        case (idx)
            REG_NOISE_FLOOR: width = NF_W;
            REG_VISIBLE_THR: width = VT_W;
            REG_POSSESS_THR: width = PT_W;
            default: width = 0;
        endcase
        raw = (width == 0) ? $urandom() : (value | ($urandom() << width));
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= raw;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        case (idx)
            REG_NOISE_FLOOR: floor_cfg = raw[NF_W-1:0];
            REG_VISIBLE_THR: visible_cfg = raw[VT_W-1:0];
            REG_POSSESS_THR: possess_cfg = raw[PT_W-1:0];
            default: ;
        endcase
        if (width == 0) begin
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end else begin
            stored = 32'(raw & ((32'd1 << width) - 1));
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            if (prdata !== stored) begin
                $display("%0t: readback reg %0d expected %0d actual %0d",
                         $time, idx, stored, prdata);
                errors++;
            end
            @(negedge i_clk);
            psel <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic set_thresholds(input int nf, input int vt, input int pt);
        drain();
        write_reg(REG_NOISE_FLOOR, nf);
        write_reg(REG_VISIBLE_THR, vt);
        write_reg(REG_POSSESS_THR, pt);
    endtask

    task automatic test_reset_thresholds;
        send_sweep(make_sweep(0, 0, 0, 0, 0, 0, 0, 0));
        send_sweep(make_sweep(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023));
        for (int k = 0; k < 7; k++) send_sweep(80'(SMP_MAX) << (k * SAMPLE_W));
        send_sweep(make_sweep(9, 9, 9, 9, 9, 9, 9, 100));
        send_sweep(make_sweep(10, 10, 10, 10, 10, 10, 10, 101));
        send_sweep(make_sweep(0, 0, 0, 10, 0, 0, 0, 0));
        send_sweep(make_sweep(0, 0, 0, 11, 0, 0, 0, 0));
        send_sweep(make_sweep(0, 0, 11, 10, 0, 0, 0, 0));
        send_sweep(make_sweep(0, 0, 0, 0, 10, 13, 0, 0));
        send_sweep(make_sweep(1023, 0, 0, 0, 0, 0, 1022, 0));
        send_sweep(make_sweep(0, 0, 0, 0, 0, 0, 0, 1023));
        send_sweep(make_sweep(682, 341, 682, 341, 682, 341, 682, 341));
        send_sweep(make_sweep(341, 682, 341, 682, 341, 682, 341, 682));
    endtask

    task automatic test_threshold_extremes;
        set_thresholds(0, 0, 0);
        send_sweep(make_sweep(0, 0, 0, 0, 0, 0, 0, 0));
        send_sweep(make_sweep(1, 0, 0, 0, 0, 0, 0, 0));
        send_sweep(make_sweep(0, 0, 0, 0, 0, 0, 0, 1));
        set_thresholds(SMP_MAX, VIS_MAX, SMP_MAX);
        send_sweep(make_sweep(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023));
        send_sweep(make_sweep(1022, 1022, 1022, 1022, 1022, 1022, 1022, 1022));
        send_sweep(make_sweep(0, 1023, 0, 0, 0, 0, 0, 0));
        drain();
        write_reg(REG_UNUSED, 0);
        send_sweep(make_sweep(0, 1023, 0, 0, 0, 1022, 0, 1023));
        set_thresholds(NOISE_FLOOR_RST, VISIBLE_THR_RST, POSSESS_THR_RST);
    endtask

    task automatic test_random_sweeps(input int n_items, input int idle_pct, input int stall_pct);
        int nf;
        int vt;
        int pt;
        int smp[8];
        drain();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int blk = 0; blk < 4; blk++) begin
            case ($urandom_range(3))
                0: nf = 0;
                1: nf = $urandom_range(SMP_MAX);
                default: nf = $urandom_range(60);
            endcase
            case ($urandom_range(3))
                0: vt = 0;
                1: vt = VIS_MAX;
                default: vt = $urandom_range(3000);
            endcase
            pt = ($urandom_range(3) == 0) ? SMP_MAX : $urandom_range(SMP_MAX);
            set_thresholds(nf, vt, pt);
            for (int i = 0; i < n_items / 4; i++) begin
                for (int k = 0; k < 7; k++) smp[k] = pick_sample(int'(floor_cfg));
                smp[7] = pick_sample(int'(possess_cfg));
                send_sweep(make_sweep(smp[0], smp[1], smp[2], smp[3],
                                      smp[4], smp[5], smp[6], smp[7]));
            end
        end
    endtask

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_sweep_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_bearings.size() == 0) begin
                $display("%0t: unexpected word bearing=%0d tuser=%b",
                         $time, $signed(m_tdata), m_tuser);
                errors++;
            end else begin
                want = pending_bearings.pop_front();
                if (m_tdata !== want.bearing) begin
                    $display("%0t: bearing expected %0d actual %0d",
                             $time, want.bearing, $signed(m_tdata));
                    errors++;
                end
                if (m_tuser[0] !== want.valid) begin
                    $display("%0t: bearing_valid expected %b actual %b",
                             $time, want.valid, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[2:1] !== want.status) begin
                    $display("%0t: target_status expected %0d actual %0d",
                             $time, want.status, m_tuser[2:1]);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_idle_pct = 7;
        recv_stall_pct = 48;
        test_reset_thresholds();
        test_threshold_extremes();
        test_random_sweeps(160, 7, 48);
        test_random_sweeps(160, 48, 7);
        test_random_sweeps(160, 0, 0);
        drain();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/sabc_pkg.sv
hdl/sabc_front.sv
hdl/sabc_queue.sv
hdl/sabc_back.sv
hdl/sensor_array_bearing_centroid.sv
tb/sensor_array_bearing_centroid_tb.sv
